// File: rtl/core/cfir_pkg.sv
// Shared constants and control types of the complex FIR low-pass filter.
package cfir_pkg;

  // Width and reset value of the filter order register.
  localparam int ORDER_W = 7;
  localparam logic [ORDER_W-1:0] RESET_ORDER = 7'd32;

  // Request kinds carried in the input tuser bit.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  // Per-cycle control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic start;    // clear the accumulators for a new sample
    logic step;     // one tap is presented at the head of the chain
    logic use_tap;  // the presented tap lies within the active order
    logic last;     // final step of the rotation
  } mac_ctrl_t;

endpackage

// File: rtl/core/cfir_cell.sv
// One delay cell of the I/Q sample chain, shifting forward or rotating back.
module cfir_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_en_i,
  input  logic                          rot_en_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_i_i,
  input  logic signed [SAMPLE_BITS-1:0] prev_q_i,
  input  logic signed [SAMPLE_BITS-1:0] next_i_i,
  input  logic signed [SAMPLE_BITS-1:0] next_q_i,
  output logic signed [SAMPLE_BITS-1:0] tap_i_o,
  output logic signed [SAMPLE_BITS-1:0] tap_q_o
);

  logic signed [SAMPLE_BITS-1:0] val_i_q;
  logic signed [SAMPLE_BITS-1:0] val_q_q;

  // A new sample pushes data toward older cells; a rotation pulls it back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_i_q <= '0;
      val_q_q <= '0;
    end else if (shift_en_i) begin
      val_i_q <= prev_i_i;
      val_q_q <= prev_q_i;
    end else if (rot_en_i) begin
      val_i_q <= next_i_i;
      val_q_q <= next_q_i;
    end
  end

  assign tap_i_o = val_i_q;
  assign tap_q_o = val_q_q;

endmodule

// File: rtl/core/cfir_mac.sv
// Coefficient memory, tap multipliers, exact accumulators and output scaling.
module cfir_mac
  import cfir_pkg::*;
#(
  parameter int MAX_TAPS    = 128,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18,
  parameter int IDX_W       = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mac_ctrl_t                     ctrl_i,
  input  logic [IDX_W-1:0]              rd_addr_i,
  input  logic                          wr_en_i,
  input  logic [IDX_W-1:0]              wr_addr_i,
  input  logic signed [COEF_BITS-1:0]   wr_data_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i_i,
  input  logic signed [SAMPLE_BITS-1:0] x_q_i,
  output logic signed [SAMPLE_BITS-1:0] y_i_o,
  output logic signed [SAMPLE_BITS-1:0] y_q_o,
  output logic                          clip_o,
  output logic                          done_o
);

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + IDX_W;
  localparam int SH     = COEF_BITS - 1;
  localparam int RND_W  = ACC_W + 1 - SH;
  localparam logic signed [ACC_W:0] HALF =
    {{(ACC_W + 1 - SH){1'b0}}, 1'b1, {(SH - 1){1'b0}}};
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-(2 ** (SAMPLE_BITS - 1)));

  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef_rd_q;
  logic signed [COEF_BITS-1:0]   coef_eff;
  logic signed [SAMPLE_BITS-1:0] s1_xi_q, s1_xq_q;
  logic                          s1_vld_q, s1_use_q, s1_last_q;
  logic signed [PROD_W-1:0]      prod_i_q, prod_q_q;
  logic                          s2_vld_q, s2_last_q;
  logic signed [ACC_W-1:0]       acc_i_q, acc_q_q;
  logic                          done_q;
  logic                          rd_en;
  logic signed [ACC_W:0]         rnd_sum_i, rnd_sum_q;
  logic signed [RND_W-1:0]       rnd_i, rnd_q;
  logic                          hi_i, lo_i, hi_q, lo_q;

  assign rd_en = ctrl_i.step && ctrl_i.use_tap;

  // Coefficient store: one write port for loads and the clearing pass, one read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      coef_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en) begin
      coef_rd_q <= coef_mem[rd_addr_i];
    end
  end

  // Stage one: sample tap aligned with the registered coefficient.
  always_ff @(posedge clk_i) begin
    s1_xi_q <= x_i_i;
    s1_xq_q <= x_q_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_use_q  <= 1'b0;
      s1_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= ctrl_i.step;
      s1_use_q  <= ctrl_i.use_tap;
      s1_last_q <= ctrl_i.last;
    end
  end

  // Taps beyond the active order contribute nothing.
  assign coef_eff = s1_use_q ? coef_rd_q : '0;

  // Stage two: products.
  always_ff @(posedge clk_i) begin
    prod_i_q <= coef_eff * s1_xi_q;
    prod_q_q <= coef_eff * s1_xq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
    end else begin
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_vld_q && s1_last_q;
    end
  end

  // Stage three: exact accumulation, cleared when a sample is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
      done_q  <= 1'b0;
    end else if (ctrl_i.start) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (s2_vld_q) begin
        acc_i_q <= acc_i_q + ACC_W'(prod_i_q);
        acc_q_q <= acc_q_q + ACC_W'(prod_q_q);
      end
      done_q <= s2_vld_q && s2_last_q;
    end
  end

  // Round to nearest with ties upward, then saturate to the sample width.
  assign rnd_sum_i = {acc_i_q[ACC_W-1], acc_i_q} + HALF;
  assign rnd_sum_q = {acc_q_q[ACC_W-1], acc_q_q} + HALF;
  assign rnd_i     = rnd_sum_i[ACC_W:SH];
  assign rnd_q     = rnd_sum_q[ACC_W:SH];
  assign hi_i      = rnd_i > SAT_HI;
  assign lo_i      = rnd_i < SAT_LO;
  assign hi_q      = rnd_q > SAT_HI;
  assign lo_q      = rnd_q < SAT_LO;

  always_comb begin
    y_i_o = rnd_i[SAMPLE_BITS-1:0];
    if (hi_i) begin
      y_i_o = SAT_HI[SAMPLE_BITS-1:0];
    end else if (lo_i) begin
      y_i_o = SAT_LO[SAMPLE_BITS-1:0];
    end
    y_q_o = rnd_q[SAMPLE_BITS-1:0];
    if (hi_q) begin
      y_q_o = SAT_HI[SAMPLE_BITS-1:0];
    end else if (lo_q) begin
      y_q_o = SAT_LO[SAMPLE_BITS-1:0];
    end
  end

  assign clip_o = hi_i || lo_i || hi_q || lo_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/complex_fir_lowpass.sv
// Top level of the complex FIR low-pass filter: stream ports, sequencer and tap chain.
//
// Real-coefficient FIR on complex I/Q samples. The input tuser bit selects the
// transaction kind: a coefficient load is absorbed on acceptance and gives no output;
// a sample gives one output transaction, and the input reopens when that result is
// loaded into the output register, later while an earlier result still waits at the
// output. The tap chain holds the sample history in a row of MAX_TAPS cells and
// rotates it once through a full revolution so that every tap passes a single pair
// of multipliers; the last product then passes the stage one and stage two registers,
// the sum is handed to the output stage and goes into the output register. After
// reset the coefficient memory is cleared to zero in a pass over all MAX_TAPS entries
// before the first input is accepted; order register writes are taken at any time
// but must only be issued while the filter is idle.
module complex_fir_lowpass
  import cfir_pkg::*;
#(
  parameter int MAX_TAPS    = 128,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 18
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: sample_i, sample_q, coef_index, coef_value, zero padding.
  input  logic [((2*SAMPLE_BITS+ORDER_W+COEF_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: req_type.
  input  logic                   s_axis_tuser,
  // Output stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: filtered_i, filtered_q, zero padding.
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tuser: clipped.
  output logic                   m_axis_tuser,
  // Filter order register write channel.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [ORDER_W-1:0]     cfg_data_i
);

  localparam int IDX_W   = $clog2(MAX_TAPS);
  localparam int OUT_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int IDX_LSB = 2 * SAMPLE_BITS;
  localparam int VAL_LSB = IDX_LSB + ORDER_W;
  localparam logic [IDX_W-1:0] LAST_TAP = IDX_W'(MAX_TAPS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [IDX_W-1:0]              cnt_q, cnt_d;
  logic [ORDER_W-1:0]            order_q;
  logic [IDX_W-1:0]              order_eff;
  logic                          in_acc, sample_acc, coef_acc, out_load;
  logic                          req_type;
  logic signed [SAMPLE_BITS-1:0] in_sample_i, in_sample_q;
  logic [ORDER_W-1:0]            in_coef_index;
  logic signed [COEF_BITS-1:0]   in_coef_value;
  logic                          rot_en;
  mac_ctrl_t                     mac_ctrl;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic signed [COEF_BITS-1:0]   wr_data;
  logic signed [SAMPLE_BITS-1:0] tap_i [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] tap_q [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] prv_i [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] prv_q [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] nxt_i [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] nxt_q [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] y_i, y_q;
  logic                          y_clip, mac_done;
  logic                          m_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_i_q, out_q_q;
  logic                          out_clip_q;

  // Unpack the input transaction.
  assign req_type      = s_axis_tuser;
  assign in_sample_i   = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_sample_q   = s_axis_tdata[IDX_LSB-1:SAMPLE_BITS];
  assign in_coef_index = s_axis_tdata[VAL_LSB-1:IDX_LSB];
  assign in_coef_value = s_axis_tdata[VAL_LSB+COEF_BITS-1:VAL_LSB];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign sample_acc    = in_acc && (req_type == REQ_SAMPLE);
  assign coef_acc      = in_acc && (req_type == REQ_COEF);

  // Filter order register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= RESET_ORDER;
    end else if (cfg_valid_i && cfg_ready_o) begin
      order_q <= cfg_data_i;
    end
  end

  // The order cannot exceed the length of the chain.
  assign order_eff = (32'(order_q) > MAX_TAPS - 1) ? LAST_TAP : IDX_W'(order_q);

  // Sequencer: clearing pass, idle, tap rotation, pipeline drain, result hand-off.
  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_TAP) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (sample_acc) begin
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_TAP) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Control to the multiply-accumulate unit; the step count is the tap delay.
  assign rot_en           = (state_q == ST_RUN);
  assign mac_ctrl.start   = sample_acc;
  assign mac_ctrl.step    = rot_en;
  assign mac_ctrl.use_tap = cnt_q <= order_eff;
  assign mac_ctrl.last    = cnt_q == LAST_TAP;

  // Memory writes come from the clearing pass or from a coefficient load.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q;
    wr_data = '0;
    if (state_q == ST_CLEAR) begin
      wr_en = 1'b1;
    end else if (coef_acc && (32'(in_coef_index) < MAX_TAPS)) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(in_coef_index);
      wr_data = in_coef_value;
    end
  end

  // Tap chain: cell k holds the sample delayed by k; rotation brings each to cell 0.
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_chain
    if (k == 0) begin : g_head
      assign prv_i[k] = in_sample_i;
      assign prv_q[k] = in_sample_q;
    end else begin : g_body
      assign prv_i[k] = tap_i[k-1];
      assign prv_q[k] = tap_q[k-1];
    end
    if (k == MAX_TAPS - 1) begin : g_tail
      assign nxt_i[k] = tap_i[0];
      assign nxt_q[k] = tap_q[0];
    end else begin : g_link
      assign nxt_i[k] = tap_i[k+1];
      assign nxt_q[k] = tap_q[k+1];
    end

    cfir_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_en_i(sample_acc),
      .rot_en_i  (rot_en),
      .prev_i_i  (prv_i[k]),
      .prev_q_i  (prv_q[k]),
      .next_i_i  (nxt_i[k]),
      .next_q_i  (nxt_q[k]),
      .tap_i_o   (tap_i[k]),
      .tap_q_o   (tap_q[k])
    );
  end

  cfir_mac #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEF_BITS  (COEF_BITS),
    .IDX_W      (IDX_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .rd_addr_i(order_eff - cnt_q),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .x_i_i    (tap_i[0]),
    .x_q_i    (tap_q[0]),
    .y_i_o    (y_i),
    .y_q_o    (y_q),
    .clip_o   (y_clip),
    .done_o   (mac_done)
  );

  // Output register; holds a result until the downstream side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_i_q    <= y_i;
      out_q_q    <= y_q;
      out_clip_q <= y_clip;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({out_q_q, out_i_q});
  assign m_axis_tuser  = out_clip_q;

  // A sample transaction closes the input until its result is handed off.
  a_sample_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_acc |=> !s_axis_tready)
    else $error("input accepted during a filter run");

  // The accumulation ends only after the rotation has finished.
  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_DRAIN || state_q == ST_DONE))
    else $error("accumulation finished outside the drain phase");

  // A new result appears only from the hand-off state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
    else $error("output valid raised without a finished result");

  // The rotation covers the whole chain and then drains.
  a_rotation_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q == LAST_TAP) |=> state_q == ST_DRAIN)
    else $error("tap rotation did not end after a full revolution");

endmodule
